// File: rtl/kcc_pkg.sv
`default_nettype none
package kcc_pkg;

  localparam int MAX_NODES  = 4096;
  localparam int NODE_W     = 12;
  localparam int NCNT_W     = NODE_W + 1;
  localparam int MAX_EDGES  = 65536;
  localparam int EDGE_AW    = 16;
  localparam int ECNT_W     = EDGE_AW + 1;
  localparam int MAX_K      = 16;
  localparam int LVL_W      = 5;
  localparam int LVL_AW     = LVL_W + NODE_W;
  localparam int LVL_DEPTH  = (MAX_K + 1) * MAX_NODES;
  localparam int BASE_LEVEL = 2;
  localparam int COUNT_W    = 64;

  localparam logic [LVL_W-1:0] CLIQUE_RESET = LVL_W'(3);

  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_FINISH = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [NODE_W-1:0] src_node;
    logic [NODE_W-1:0] dst_node;
  } in_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] clique_count;
    logic               edge_overflow;
  } out_item_t;

  function automatic logic [LVL_AW-1:0] lvl_addr(input logic [LVL_W-1:0] lvl,
                                                 input logic [NODE_W-1:0] node);
    lvl_addr = {lvl, node};
  endfunction

endpackage
`default_nettype wire

// File: rtl/k_clique_counter_unit.sv
`default_nettype none
// Channel  | Signals                         | Transfer when
// ---------+---------------------------------+------------------------------
// in       | in_valid, in_ready, in_data     | in_valid & in_ready
// out      | out_valid, out_ready, out_data  | out_valid & out_ready
// cfg      | cfg_wr_en, cfg_wr_data          | cfg_wr_en (no wait)
//
// Edge loads are written straight into the edge memory.
// A finish item runs the build (its degree updates are read-modify-writes
// on memories with a single read port), then the search. The result sits in an
// output register. Reset is synchronous and clears no store; each finish first
// initialises the per-node stores, and every other store is rewritten before use.
// A finish waits in its last state while an earlier result is still untaken.
module k_clique_counter_unit (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire kcc_pkg::in_item_t       in_data,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output kcc_pkg::out_item_t           out_data,
  input  wire logic                    cfg_wr_en,
  input  wire logic [kcc_pkg::LVL_W-1:0] cfg_wr_data
);

  typedef enum logic [38:0] {
    S_IDLE    = 39'd1 << 0,  S_ZERO    = 39'd1 << 1,  S_DEG_RD  = 39'd1 << 2,
    S_DEG_S   = 39'd1 << 3,  S_DEG_SW  = 39'd1 << 4,  S_DEG_T   = 39'd1 << 5,
    S_DEG_TW  = 39'd1 << 6,  S_OR_RD   = 39'd1 << 7,  S_OR_S    = 39'd1 << 8,
    S_OR_T    = 39'd1 << 9,  S_OR_CMP  = 39'd1 << 10, S_OR_INC  = 39'd1 << 11,
    S_ROW_RD  = 39'd1 << 12, S_ROW_WR  = 39'd1 << 13, S_FIL_RD  = 39'd1 << 14,
    S_FIL_S   = 39'd1 << 15, S_FIL_W   = 39'd1 << 16, S_TOP     = 39'd1 << 17,
    S_UP      = 39'd1 << 18, S_UP_RD   = 39'd1 << 19, S_UP_M    = 39'd1 << 20,
    S_BASE_RD = 39'd1 << 21, S_BASE_M  = 39'd1 << 22, S_BASE_D  = 39'd1 << 23,
    S_DSC_RD  = 39'd1 << 24, S_DSC_U   = 39'd1 << 25, S_DSC_E   = 39'd1 << 26,
    S_P1_RD   = 39'd1 << 27, S_P1_V    = 39'd1 << 28, S_P1_L    = 39'd1 << 29,
    S_P2_RD   = 39'd1 << 30, S_P2_M    = 39'd1 << 31, S_P2_E    = 39'd1 << 32,
    S_P3_RD   = 39'd1 << 33, S_P3_W    = 39'd1 << 34, S_P3_L    = 39'd1 << 35,
    S_P3_X    = 39'd1 << 36, S_P3_Y    = 39'd1 << 37, S_DONE    = 39'd1 << 38
  } state_t;

  localparam int NW = kcc_pkg::NODE_W;
  localparam int EW = kcc_pkg::ECNT_W;
  localparam int LW = kcc_pkg::LVL_W;
  localparam int CW = kcc_pkg::NCNT_W;
  localparam int AW = kcc_pkg::LVL_AW;
  localparam int QW = kcc_pkg::EDGE_AW;
  localparam logic [LW-1:0] BASE = LW'(kcc_pkg::BASE_LEVEL);
  localparam logic [LW-1:0] KMAX = LW'(kcc_pkg::MAX_K);

  state_t           state;
  logic [LW-1:0]    clique_size;
  logic [LW-1:0]    kk;
  logic [LW-1:0]    lvl;
  logic [EW-1:0]    idx;
  logic [EW-1:0]    e_cnt;
  logic [NW-1:0]    hi_node;
  logic             ovf;
  logic [NW-1:0]    s_reg;
  logic [NW-1:0]    t_reg;
  logic [NW-1:0]    vreg;
  logic [EW-1:0]    ds;
  logic [EW-1:0]    acc;
  logic [EW-1:0]    dacc;
  logic [EW-1:0]    pos;
  logic [EW-1:0]    pend;
  logic [CW-1:0]    cnt;
  logic [kcc_pkg::COUNT_W-1:0] run;
  logic [CW-1:0]    lsize  [0:kcc_pkg::MAX_K];
  logic [CW-1:0]    sstack [0:kcc_pkg::MAX_K];

  logic [LW-1:0]    lvl_lo;
  logic [CW-1:0]    n_nodes;
  logic             in_xfer;
  logic             swap;
  logic [kcc_pkg::COUNT_W:0] run_sum;

  // memory ports
  logic                 e_we;
  logic [QW-1:0]        e_waddr, e_raddr;
  logic [2*NW-1:0]      e_wdata, e_rdata;
  logic                 f_we;
  logic [NW-1:0]        f_waddr, f_raddr;
  logic [EW-1:0]        f_wdata, f_rdata;
  logic                 r_we;
  logic [CW-1:0]        r_waddr, r_raddr;
  logic [EW-1:0]        r_wdata, r_rdata;
  logic                 n_we;
  logic [QW-1:0]        n_waddr, n_raddr;
  logic [NW-1:0]        n_wdata, n_rdata;
  logic                 d_we;
  logic [AW-1:0]        d_waddr, d_raddr;
  logic [EW-1:0]        d_wdata, d_rdata;
  logic                 m_we;
  logic [AW-1:0]        m_waddr, m_raddr;
  logic [NW-1:0]        m_wdata, m_rdata;
  logic                 b_we;
  logic [NW-1:0]        b_waddr, b_raddr;
  logic [LW-1:0]        b_wdata, b_rdata;

  kcc_ram #(.WIDTH(2*NW), .DEPTH(kcc_pkg::MAX_EDGES)) u_edge (
    .clk, .we(e_we), .waddr(e_waddr), .wdata(e_wdata), .raddr(e_raddr), .rdata(e_rdata));
  kcc_ram #(.WIDTH(EW), .DEPTH(kcc_pkg::MAX_NODES)) u_fdeg (
    .clk, .we(f_we), .waddr(f_waddr), .wdata(f_wdata), .raddr(f_raddr), .rdata(f_rdata));
  kcc_ram #(.WIDTH(EW), .DEPTH(kcc_pkg::MAX_NODES + 1)) u_rows (
    .clk, .we(r_we), .waddr(r_waddr), .wdata(r_wdata), .raddr(r_raddr), .rdata(r_rdata));
  kcc_ram #(.WIDTH(NW), .DEPTH(kcc_pkg::MAX_EDGES)) u_nbr (
    .clk, .we(n_we), .waddr(n_waddr), .wdata(n_wdata), .raddr(n_raddr), .rdata(n_rdata));
  kcc_ram #(.WIDTH(EW), .DEPTH(kcc_pkg::LVL_DEPTH)) u_ldeg (
    .clk, .we(d_we), .waddr(d_waddr), .wdata(d_wdata), .raddr(d_raddr), .rdata(d_rdata));
  kcc_ram #(.WIDTH(NW), .DEPTH(kcc_pkg::LVL_DEPTH)) u_lmem (
    .clk, .we(m_we), .waddr(m_waddr), .wdata(m_wdata), .raddr(m_raddr), .rdata(m_rdata));
  kcc_ram #(.WIDTH(LW), .DEPTH(kcc_pkg::MAX_NODES)) u_label (
    .clk, .we(b_we), .waddr(b_waddr), .wdata(b_wdata), .raddr(b_raddr), .rdata(b_rdata));

  assign in_ready = (state == S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign lvl_lo   = lvl - LW'(1);
  assign n_nodes  = CW'(hi_node) + CW'(1);
  // orient from lower degree; on a tie, lower id is the source
  assign swap     = (ds > f_rdata) || ((ds == f_rdata) && (s_reg > t_reg));
  assign run_sum  = {1'b0, run} + (kcc_pkg::COUNT_W + 1)'(d_rdata);

  // memory control: address issued in one state, data used in the next
  always_comb begin
    e_we = 1'b0; e_waddr = idx[QW-1:0]; e_wdata = {s_reg, t_reg}; e_raddr = idx[QW-1:0];
    f_we = 1'b0; f_waddr = s_reg; f_wdata = f_rdata + EW'(1); f_raddr = s_reg;
    r_we = 1'b0; r_waddr = '0; r_wdata = '0; r_raddr = CW'(s_reg);
    n_we = 1'b0; n_waddr = pos[QW-1:0]; n_wdata = t_reg; n_raddr = pos[QW-1:0];
    d_we = 1'b0; d_waddr = kcc_pkg::lvl_addr(kk, s_reg); d_wdata = d_rdata + EW'(1);
    d_raddr = kcc_pkg::lvl_addr(kk, s_reg);
    m_we = 1'b0; m_waddr = kcc_pkg::lvl_addr(lvl_lo, cnt[NW-1:0]); m_wdata = vreg;
    m_raddr = kcc_pkg::lvl_addr(lvl_lo, idx[NW-1:0]);
    b_we = 1'b0; b_waddr = vreg; b_wdata = lvl_lo; b_raddr = n_rdata;
    case (state)
      S_IDLE: begin
        if (in_xfer && in_data.kind == kcc_pkg::KIND_LOAD
            && e_cnt < EW'(kcc_pkg::MAX_EDGES)) begin
          e_we    = 1'b1;
          e_waddr = e_cnt[QW-1:0];
          e_wdata = {in_data.src_node, in_data.dst_node};
        end
        if (in_xfer && in_data.kind == kcc_pkg::KIND_FINISH) begin
          r_we = 1'b1;
        end
      end
      S_ZERO: begin
        f_we = 1'b1; f_waddr = idx[NW-1:0]; f_wdata = '0;
        d_we = 1'b1; d_waddr = kcc_pkg::lvl_addr(kk, idx[NW-1:0]); d_wdata = '0;
        m_we = 1'b1; m_waddr = kcc_pkg::lvl_addr(kk, idx[NW-1:0]); m_wdata = idx[NW-1:0];
        b_we = 1'b1; b_waddr = idx[NW-1:0]; b_wdata = kk;
      end
      S_DEG_S, S_OR_S: f_raddr = e_rdata[2*NW-1:NW];
      S_DEG_SW: f_we = 1'b1;
      S_DEG_T, S_OR_T: f_raddr = t_reg;
      S_DEG_TW: begin
        f_we = 1'b1; f_waddr = t_reg;
      end
      S_OR_CMP: begin
        e_we    = 1'b1;
        e_wdata = swap ? {t_reg, s_reg} : {s_reg, t_reg};
        d_raddr = kcc_pkg::lvl_addr(kk, swap ? t_reg : s_reg);
      end
      S_OR_INC: d_we = 1'b1;
      S_ROW_RD: d_raddr = kcc_pkg::lvl_addr(kk, idx[NW-1:0]);
      S_ROW_WR: begin
        r_we = 1'b1; r_waddr = idx[CW-1:0] + CW'(1); r_wdata = acc + d_rdata;
        d_we = 1'b1; d_waddr = kcc_pkg::lvl_addr(kk, idx[NW-1:0]); d_wdata = '0;
      end
      S_FIL_S: begin
        r_raddr = CW'(e_rdata[2*NW-1:NW]);
        d_raddr = kcc_pkg::lvl_addr(kk, e_rdata[2*NW-1:NW]);
      end
      S_FIL_W: begin
        n_we = 1'b1; n_waddr = QW'(r_rdata + d_rdata); n_wdata = t_reg;
        d_we = 1'b1;
      end
      S_UP_RD: m_raddr = kcc_pkg::lvl_addr(lvl_lo, idx[NW-1:0]);
      S_UP_M: begin
        b_we = 1'b1; b_waddr = m_rdata; b_wdata = lvl;
      end
      S_BASE_RD: m_raddr = kcc_pkg::lvl_addr(BASE, idx[NW-1:0]);
      S_BASE_M: d_raddr = kcc_pkg::lvl_addr(BASE, m_rdata);
      S_DSC_RD: m_raddr = kcc_pkg::lvl_addr(lvl, sstack[lvl][NW-1:0]);
      S_DSC_U, S_P2_M: begin
        r_raddr = CW'(m_rdata);
        d_raddr = kcc_pkg::lvl_addr(lvl, m_rdata);
      end
      S_P1_L: begin
        if (b_rdata == lvl) begin
          b_we = 1'b1;
          m_we = 1'b1;
        end
      end
      S_P3_RD: begin
        if (pos >= pend) begin
          d_we = 1'b1; d_waddr = kcc_pkg::lvl_addr(lvl_lo, vreg); d_wdata = dacc;
        end
      end
      S_P3_L: n_raddr = QW'(pend - EW'(1));
      S_P3_X: begin
        n_we = 1'b1; n_wdata = n_rdata;
      end
      S_P3_Y: begin
        n_we = 1'b1; n_waddr = pend[QW-1:0]; n_wdata = t_reg;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      clique_size <= kcc_pkg::CLIQUE_RESET;
      e_cnt       <= '0;
      hi_node     <= '0;
      ovf         <= 1'b0;
      run         <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        clique_size <= cfg_wr_data;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            if (in_data.kind == kcc_pkg::KIND_LOAD) begin
              if (e_cnt >= EW'(kcc_pkg::MAX_EDGES)) begin
                ovf <= 1'b1;
              end else begin
                e_cnt <= e_cnt + EW'(1);
                if (in_data.src_node > hi_node && in_data.src_node >= in_data.dst_node) begin
                  hi_node <= in_data.src_node;
                end else if (in_data.dst_node > hi_node) begin
                  hi_node <= in_data.dst_node;
                end
              end
            end else begin
              // clamp k into the supported range
              if (clique_size < BASE)      kk <= BASE;
              else if (clique_size > KMAX) kk <= KMAX;
              else                         kk <= clique_size;
              idx   <= '0;
              acc   <= '0;
              run   <= '0;
              state <= S_ZERO;
            end
          end
        end
        S_ZERO: begin
          if (idx + EW'(1) == EW'(n_nodes)) begin
            idx   <= '0;
            state <= S_DEG_RD;
          end else begin
            idx <= idx + EW'(1);
          end
        end
        S_DEG_RD: begin
          if (idx >= e_cnt) begin
            idx   <= '0;
            state <= S_OR_RD;
          end else begin
            state <= S_DEG_S;
          end
        end
        S_DEG_S: begin
          s_reg <= e_rdata[2*NW-1:NW];
          t_reg <= e_rdata[NW-1:0];
          state <= S_DEG_SW;
        end
        S_DEG_SW: state <= S_DEG_T;
        S_DEG_T:  state <= S_DEG_TW;
        S_DEG_TW: begin
          idx   <= idx + EW'(1);
          state <= S_DEG_RD;
        end
        S_OR_RD: begin
          if (idx >= e_cnt) begin
            idx   <= '0;
            state <= S_ROW_RD;
          end else begin
            state <= S_OR_S;
          end
        end
        S_OR_S: begin
          s_reg <= e_rdata[2*NW-1:NW];
          t_reg <= e_rdata[NW-1:0];
          state <= S_OR_T;
        end
        S_OR_T: begin
          ds    <= f_rdata;
          state <= S_OR_CMP;
        end
        S_OR_CMP: begin
          s_reg <= swap ? t_reg : s_reg;
          state <= S_OR_INC;
        end
        S_OR_INC: begin
          idx   <= idx + EW'(1);
          state <= S_OR_RD;
        end
        S_ROW_RD: begin
          if (idx >= EW'(n_nodes)) begin
            idx       <= '0;
            lsize[kk] <= n_nodes;
            state     <= S_FIL_RD;
          end else begin
            state <= S_ROW_WR;
          end
        end
        S_ROW_WR: begin
          acc   <= acc + d_rdata;
          idx   <= idx + EW'(1);
          state <= S_ROW_RD;
        end
        S_FIL_RD: begin
          if (idx >= e_cnt) begin
            lvl        <= kk;
            sstack[kk] <= '0;
            state      <= S_TOP;
          end else begin
            state <= S_FIL_S;
          end
        end
        S_FIL_S: begin
          s_reg <= e_rdata[2*NW-1:NW];
          t_reg <= e_rdata[NW-1:0];
          state <= S_FIL_W;
        end
        S_FIL_W: begin
          idx   <= idx + EW'(1);
          state <= S_FIL_RD;
        end
        S_TOP: begin
          idx <= '0;
          if (lvl == BASE)                    state <= S_BASE_RD;
          else if (sstack[lvl] >= lsize[lvl]) state <= S_UP;
          else                                state <= S_DSC_RD;
        end
        S_UP: begin
          if (lvl == kk) begin
            state <= S_DONE;
          end else begin
            lvl   <= lvl + LW'(1);
            idx   <= '0;
            state <= S_UP_RD;
          end
        end
        S_UP_RD: begin
          // relabel the members of the level just left
          if (idx >= EW'(lsize[lvl_lo])) begin
            sstack[lvl] <= sstack[lvl] + CW'(1);
            state       <= S_TOP;
          end else begin
            state <= S_UP_M;
          end
        end
        S_UP_M: begin
          idx   <= idx + EW'(1);
          state <= S_UP_RD;
        end
        S_BASE_RD: begin
          if (idx >= EW'(lsize[BASE])) state <= S_UP;
          else                         state <= S_BASE_M;
        end
        S_BASE_M: state <= S_BASE_D;
        S_BASE_D: begin
          run   <= run_sum[kcc_pkg::COUNT_W] ? '1 : run_sum[kcc_pkg::COUNT_W-1:0];
          idx   <= idx + EW'(1);
          state <= S_BASE_RD;
        end
        S_DSC_RD: state <= S_DSC_U;
        S_DSC_U:  state <= S_DSC_E;
        S_DSC_E: begin
          pos   <= r_rdata;
          pend  <= r_rdata + d_rdata;
          cnt   <= '0;
          state <= S_P1_RD;
        end
        S_P1_RD: begin
          if (pos >= pend) begin
            lsize[lvl_lo] <= cnt;
            idx           <= '0;
            state         <= S_P2_RD;
          end else begin
            state <= S_P1_V;
          end
        end
        S_P1_V: begin
          vreg  <= n_rdata;
          state <= S_P1_L;
        end
        S_P1_L: begin
          if (b_rdata == lvl) begin
            cnt <= cnt + CW'(1);
          end
          pos   <= pos + EW'(1);
          state <= S_P1_RD;
        end
        S_P2_RD: begin
          if (idx >= EW'(cnt)) begin
            lvl            <= lvl_lo;
            sstack[lvl_lo] <= '0;
            state          <= S_TOP;
          end else begin
            state <= S_P2_M;
          end
        end
        S_P2_M: begin
          vreg  <= m_rdata;
          state <= S_P2_E;
        end
        S_P2_E: begin
          pos   <= r_rdata;
          pend  <= r_rdata + d_rdata;
          dacc  <= '0;
          state <= S_P3_RD;
        end
        S_P3_RD: begin
          if (pos >= pend) begin
            idx   <= idx + EW'(1);
            state <= S_P2_RD;
          end else begin
            state <= S_P3_W;
          end
        end
        S_P3_W: begin
          t_reg <= n_rdata;
          state <= S_P3_L;
        end
        S_P3_L: begin
          // keep in-level neighbors in front, swap others past the end
          if (b_rdata == lvl_lo) begin
            dacc  <= dacc + EW'(1);
            pos   <= pos + EW'(1);
            state <= S_P3_RD;
          end else begin
            pend  <= pend - EW'(1);
            state <= S_P3_X;
          end
        end
        S_P3_X: state <= S_P3_Y;
        S_P3_Y: state <= S_P3_RD;
        S_DONE: begin
          // hold until the output register is free, then drop all counts
          if (!out_valid) begin
            out_valid              <= 1'b1;
            out_data.clique_count  <= run;
            out_data.edge_overflow <= ovf;
            e_cnt                  <= '0;
            hi_node                <= '0;
            ovf                    <= 1'b0;
            run                    <= '0;
            state                  <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_lvl_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_TOP) |-> (lvl >= BASE && lvl <= kk))
    else $error("search level out of range");

  a_swap_window: assert property (@(posedge clk) disable iff (rst)
    (state == S_P3_RD) |-> (pos <= pend))
    else $error("prune window crossed");

  a_edge_bound: assert property (@(posedge clk) disable iff (rst)
    e_cnt <= EW'(kcc_pkg::MAX_EDGES))
    else $error("edge count beyond store");

  a_finish_busy: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && in_data.kind == kcc_pkg::KIND_FINISH) |=> !in_ready)
    else $error("input taken during count");

endmodule
`default_nettype wire

// File: rtl/kcc_ram.sv
`default_nettype none
module kcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  // read returns the old word on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: tb/sv/tb_top.sv
module tb_top;
  import kcc_pkg::*;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  in_item_t in_data;
  logic out_valid;
  logic out_ready;
  out_item_t out_data;
  logic cfg_wr_en;
  logic [LVL_W-1:0] cfg_wr_data;

  k_clique_counter_unit DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  // Items waiting to be driven, and results the block still owes us.
  in_item_t pending_items[$];
  out_item_t owed_counts[$];

  // Percent of cycles that each side sits idle; the phase sets these.
  int unsigned send_idle;
  int unsigned recv_idle;
  int unsigned mismatches;

  // Shadow of the graph loaded so far and of the clique_size register.
  logic [NODE_W-1:0] edge_a[$];
  logic [NODE_W-1:0] edge_b[$];
  int unsigned top_node;
  bit dropped_edge;
  logic [LVL_W-1:0] size_reg;

  // Working stores for the clique search; sized to the block's limits.
  int unsigned node_deg[MAX_NODES];
  int unsigned row_base[MAX_NODES + 1];
  int unsigned adj[MAX_EDGES];
  int unsigned lvl_deg[MAX_K + 1][MAX_NODES];
  int unsigned lvl_mem[MAX_K + 1][MAX_NODES];
  int unsigned lvl_cnt[MAX_K + 1];
  int unsigned tag[MAX_NODES];
  int unsigned cursor[MAX_K + 1];
  logic [COUNT_W-1:0] tally;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Safety net in case the block hangs.
  initial begin
    #60000000;
    $display("k_clique_counter_unit test failed");
    $finish;
  end

  function automatic void add_sat(input int unsigned v);
    if ({COUNT_W{1'b1}} - tally < COUNT_W'(v)) tally = {COUNT_W{1'b1}};
    else tally = tally + COUNT_W'(v);
  endfunction

  // Build level l-1 out of the neighbors of u, pruning each member's row
  // down to the neighbors that also made it into the new level.
  function automatic void narrow_level(input int unsigned l, input int unsigned u);
    int unsigned lo, cnt, stop, p, v, w;
    lo = l - 1;
    cnt = 0;
    stop = row_base[u] + lvl_deg[l][u];
    for (int unsigned j = row_base[u]; j < stop; j++) begin
      v = adj[j];
      if (tag[v] == l) begin
        tag[v] = lo;
        lvl_mem[lo][cnt] = v;
        cnt++;
        lvl_deg[lo][v] = 0;
      end
    end
    lvl_cnt[lo] = cnt;
    for (int unsigned j = 0; j < cnt; j++) begin
      v = lvl_mem[lo][j];
      p = row_base[v];
      stop = p + lvl_deg[l][v];
      while (p < stop) begin
        w = adj[p];
        if (tag[w] == lo) begin
          lvl_deg[lo][v]++;
          p++;
        end else begin
          stop--;
          adj[p] = adj[stop];
          adj[stop] = w;
        end
      end
    end
  endfunction

  // Orient by degree, build rows, then walk the levels with a stack.
  function automatic logic [COUNT_W-1:0] count_cliques();
    int unsigned k, n, ne, s, t, l;
    bit done;
    logic [NODE_W-1:0] tmp;
    k = size_reg;
    if (k < BASE_LEVEL) k = BASE_LEVEL;
    if (k > MAX_K) k = MAX_K;
    n = top_node + 1;
    ne = edge_a.size();
    tally = '0;
    for (int unsigned i = 0; i < n; i++) begin
      node_deg[i] = 0;
      lvl_deg[k][i] = 0;
    end
    for (int unsigned i = 0; i < ne; i++) begin
      node_deg[edge_a[i]]++;
      node_deg[edge_b[i]]++;
    end
    for (int unsigned i = 0; i < ne; i++) begin
      s = edge_a[i];
      t = edge_b[i];
      if (node_deg[s] > node_deg[t] || (node_deg[s] == node_deg[t] && s > t)) begin
        tmp = edge_a[i];
        edge_a[i] = edge_b[i];
        edge_b[i] = tmp;
      end
    end
    for (int unsigned i = 0; i < ne; i++) lvl_deg[k][edge_a[i]]++;
    row_base[0] = 0;
    for (int unsigned i = 0; i < n; i++) begin
      row_base[i + 1] = row_base[i] + lvl_deg[k][i];
      lvl_mem[k][i] = i;
      lvl_deg[k][i] = 0;
      tag[i] = k;
    end
    for (int unsigned i = 0; i < ne; i++) begin
      s = edge_a[i];
      adj[row_base[s] + lvl_deg[k][s]] = edge_b[i];
      lvl_deg[k][s]++;
    end
    lvl_cnt[k] = n;

    l = k;
    cursor[l] = 0;
    done = 0;
    while (!done) begin
      if (l == BASE_LEVEL || cursor[l] >= lvl_cnt[l]) begin
        if (l == BASE_LEVEL)
          for (int unsigned i = 0; i < lvl_cnt[BASE_LEVEL]; i++)
            add_sat(lvl_deg[BASE_LEVEL][lvl_mem[BASE_LEVEL][i]]);
        l++;
        if (l > k) begin
          done = 1;
        end else begin
          for (int unsigned i = 0; i < lvl_cnt[l - 1]; i++) tag[lvl_mem[l - 1][i]] = l;
          cursor[l]++;
        end
      end else begin
        narrow_level(l, lvl_mem[l][cursor[l]]);
        l--;
        cursor[l] = 0;
      end
    end
    return tally;
  endfunction

  // Fold one transferred item into the shadow graph; a finish owes a result.
  function automatic void absorb_item(input in_item_t it);
    out_item_t res;
    if (it.kind == KIND_LOAD) begin
      if (edge_a.size() >= MAX_EDGES) begin
        dropped_edge = 1;
      end else begin
        edge_a.push_back(it.src_node);
        edge_b.push_back(it.dst_node);
        if (it.src_node > top_node) top_node = it.src_node;
        if (it.dst_node > top_node) top_node = it.dst_node;
      end
    end else begin
      res.clique_count = count_cliques();
      res.edge_overflow = dropped_edge;
      owed_counts.push_back(res);
      edge_a.delete();
      edge_b.delete();
      top_node = 0;
      dropped_edge = 0;
    end
  endfunction

  // Driver: advance to the next item after a transfer, or idle at random.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) absorb_item(in_data);
      if (pending_items.size() > 0 && $urandom_range(99) >= send_idle) begin
        in_data <= pending_items.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: compare each result transfer with the oldest owed count.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (owed_counts.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: count %0d overflow %0b",
                     out_data.clique_count, out_data.edge_overflow);
        end else begin
          out_item_t exp_res;
          exp_res = owed_counts.pop_front();
          if (out_data.clique_count !== exp_res.clique_count ||
              out_data.edge_overflow !== exp_res.edge_overflow) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: count exp %0d got %0d, overflow exp %0b got %0b",
                       exp_res.clique_count, out_data.clique_count,
                       exp_res.edge_overflow, out_data.edge_overflow);
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  function automatic in_item_t edge_item(input int unsigned a, input int unsigned b);
    in_item_t it;
    it.kind = KIND_LOAD;
    it.src_node = NODE_W'(a);
    it.dst_node = NODE_W'(b);
    return it;
  endfunction

  function automatic in_item_t finish_item();
    in_item_t it;
    it.kind = KIND_FINISH;
    it.src_node = NODE_W'($urandom);
    it.dst_node = NODE_W'($urandom);
    return it;
  endfunction

  // Hold the sender until every owed result has arrived, then let any
  // trailing work drain before touching the register.
  task automatic drain();
    while (pending_items.size() > 0 || in_valid || owed_counts.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_size(input logic [LVL_W-1:0] v);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    size_reg = v;
    cfg_wr_en <= 1'b0;
  endtask

  // One random graph: mostly dense over a few nodes so cliques appear,
  // sometimes sparse over the full id range, sometimes empty.
  task automatic queue_graph();
    int unsigned span, ne, a, b;
    case ($urandom_range(19))
      0: span = MAX_NODES;
      1: span = 0;
      default: span = $urandom_range(12, 3);
    endcase
    ne = (span == 0) ? 0 : $urandom_range(28, 1);
    for (int unsigned i = 0; i < ne; i++) begin
      a = $urandom_range(span - 1);
      b = ($urandom_range(19) == 0) ? a : $urandom_range(span - 1);
      pending_items.push_back(edge_item(a, b));
    end
    pending_items.push_back(finish_item());
  endtask

  initial begin
    logic [LVL_W-1:0] sizes[10];
    int unsigned fed;
    sizes = '{3, 2, 4, 16, 0, 1, 5, 17, 31, 6};
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    mismatches = 0;
    top_node = 0;
    dropped_edge = 0;
    size_reg = CLIQUE_RESET;
    send_idle = 36;
    recv_idle = 55;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty graph, triangle, K4, self-loop and duplicates, id extremes.
    pending_items.push_back(finish_item());
    pending_items.push_back(edge_item(0, 1));
    pending_items.push_back(edge_item(1, 2));
    pending_items.push_back(edge_item(2, 0));
    pending_items.push_back(finish_item());
    for (int unsigned a = 0; a < 4; a++)
      for (int unsigned b = a + 1; b < 4; b++) pending_items.push_back(edge_item(b, a));
    pending_items.push_back(edge_item(3, 3));
    pending_items.push_back(edge_item(1, 0));
    pending_items.push_back(finish_item());
    pending_items.push_back(edge_item(0, 4095));
    pending_items.push_back(edge_item(4095, 2730));
    pending_items.push_back(edge_item(2730, 0));
    pending_items.push_back(edge_item(1365, 1365));
    pending_items.push_back(finish_item());
    set_size(4);
    pending_items.push_back(edge_item(0, 1));
    pending_items.push_back(edge_item(0, 2));
    pending_items.push_back(edge_item(0, 3));
    pending_items.push_back(edge_item(1, 2));
    pending_items.push_back(edge_item(1, 3));
    pending_items.push_back(edge_item(2, 3));
    pending_items.push_back(finish_item());

    // Fill the edge store past its end with self-loops; the last one drops.
    set_size(2);
    for (int unsigned i = 0; i <= MAX_EDGES; i++) pending_items.push_back(edge_item(0, 0));
    pending_items.push_back(finish_item());
    drain();

    // Random phases, one register setting each; idling pattern shifts by thirds.
    for (int p = 0; p < 10; p++) begin
      set_size(sizes[p]);
      send_idle = (p < 3) ? 36 : (p < 6) ? 55 : 0;
      recv_idle = (p < 3) ? 55 : (p < 6) ? 36 : 0;
      fed = 0;
      while (fed < 180) begin
        int unsigned before_cnt;
        before_cnt = pending_items.size();
        queue_graph();
        fed += pending_items.size() - before_cnt;
      end
    end
    drain();
    repeat (100) @(posedge clk);

    if (mismatches == 0) begin
      $display("k_clique_counter_unit test passed");
    end else begin
      $display("k_clique_counter_unit test failed");
    end
    $finish;
  end

endmodule
